### design/constant_velocity_kalman_tracker_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the constant velocity tracker
// Immediate-consequence and next-cycle checks, empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef CONSTANT_VELOCITY_KALMAN_TRACKER_MACROS_SVH
`define CONSTANT_VELOCITY_KALMAN_TRACKER_MACROS_SVH
`ifndef SYNTH
`define CVKT_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tracker check failed");
`define CVKT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tracker check failed");
`else
`define CVKT_ASSERT_IMP(lbl, pre, post)
`define CVKT_ASSERT_NXT(lbl, pre, post)
`endif
`endif

### design/cvkt_pkg.sv
// ---------------------------------------------------------------------------
// Tracker package
// Beat types, scratch store addresses and the sequencer program.
// ---------------------------------------------------------------------------
package cvkt_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef logic [5:0] addr_t;
  typedef logic [6:0] pc_t;

  localparam addr_t A_E0  = 6'd0;
  localparam addr_t A_C0  = 6'd4;
  localparam addr_t A_PX  = 6'd14;
  localparam addr_t A_PY  = 6'd15;
  localparam addr_t A_A0  = 6'd16;
  localparam addr_t A_A1  = 6'd20;
  localparam addr_t A_B0  = 6'd24;
  localparam addr_t A_S00 = 6'd34;
  localparam addr_t A_S11 = 6'd35;
  localparam addr_t A_DET = 6'd36;
  localparam addr_t A_N   = 6'd37;
  localparam addr_t A_K0  = 6'd38;
  localparam addr_t A_EX  = 6'd46;
  localparam addr_t A_EY  = 6'd47;
  localparam addr_t A_SPECIAL = 6'd56;
  localparam addr_t A_DT  = 6'd56;
  localparam addr_t A_QP  = 6'd57;
  localparam addr_t A_QV  = 6'd58;
  localparam addr_t A_RM  = 6'd59;
  localparam addr_t A_MX  = 6'd60;
  localparam addr_t A_MY  = 6'd61;
  localparam addr_t A_ZR  = 6'd62;

  localparam logic OP_ARITH = 1'b0;
  localparam logic OP_DIV   = 1'b1;

  localparam pc_t PC_UPD  = 7'd0;
  localparam pc_t PC_INIT = 7'd59;
  localparam pc_t PC_PRED = 7'd63;
  localparam pc_t PC_MAX  = 7'd64;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  localparam int TRI_ROW [10] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
  localparam int TRI_COL [10] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};
  localparam int DIAG_K  [4]  = '{0, 4, 7, 9};

  typedef struct packed {
    logic                mode;
    logic [19:0]         dt_q16;
    logic signed [31:0]  meas_x;
    logic signed [31:0]  meas_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic                tracking;
  } out_t;

  typedef struct packed {
    logic   op;
    addr_t  c;
    addr_t  a0;
    addr_t  b0;
    logic   m0;
    logic   n0;
    addr_t  a1;
    addr_t  b1;
    logic   m1;
    logic   n1;
    addr_t  dst;
    logic   sat;
    logic   last;
  } instr_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic int tidx(input int r, input int c);
    int lo;
    int hi;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    if (lo == 0) return hi;
    if (lo == 1) return 3 + hi;
    if (lo == 2) return 5 + hi;
    return 9;
  endfunction

  function automatic addr_t cov_a(input int r, input int c);
    return A_C0 + addr_t'(tidx(r, c));
  endfunction

  function automatic addr_t b_a(input int r, input int c);
    return A_B0 + addr_t'(tidx(r, c));
  endfunction

  function automatic addr_t a_a(input int i, input int j);
    if (i == 0) return A_A0 + addr_t'(j);
    if (i == 1) return A_A1 + addr_t'(j);
    return cov_a(i, j);
  endfunction

  function automatic addr_t k_a(input int i, input int col);
    return A_K0 + addr_t'(2 * i + col);
  endfunction

  function automatic instr_t mk(input logic op, input addr_t c,
                                input addr_t a0, input addr_t b0, input logic m0,
                                input logic n0, input addr_t a1, input addr_t b1,
                                input logic m1, input logic n1, input addr_t dst,
                                input logic sat, input logic last);
    instr_t r;
    r.op = op; r.c = c; r.a0 = a0; r.b0 = b0; r.m0 = m0; r.n0 = n0;
    r.a1 = a1; r.b1 = b1; r.m1 = m1; r.n1 = n1; r.dst = dst;
    r.sat = sat; r.last = last;
    return r;
  endfunction

  function automatic instr_t prog(input pc_t pc);
    instr_t r;
    int p;
    int i;
    int j;
    int k;
    int t;
    addr_t pred;
    p = int'(pc);
    r = mk(OP_ARITH, A_ZR, A_ZR, A_ZR, 1'b0, 1'b0, A_ZR, A_ZR, 1'b0, 1'b0,
           A_ZR, 1'b1, 1'b1);
    if (p == 0 || p == 63) begin
      r = mk(OP_ARITH, A_E0, A_DT, A_E0 + 6'd2, 1'b1, 1'b0, A_ZR, A_ZR, 1'b0, 1'b0,
             A_PX, 1'b1, 1'b0);
    end else if (p == 1 || p == 64) begin
      r = mk(OP_ARITH, A_E0 + 6'd1, A_DT, A_E0 + 6'd3, 1'b1, 1'b0, A_ZR, A_ZR,
             1'b0, 1'b0, A_PY, 1'b1, p == 64);
    end else if (p >= 2 && p <= 5) begin
      j = p - 2;
      r = mk(OP_ARITH, cov_a(0, j), A_DT, cov_a(2, j), 1'b1, 1'b0, A_ZR, A_ZR,
             1'b0, 1'b0, A_A0 + addr_t'(j), 1'b1, 1'b0);
    end else if (p >= 6 && p <= 9) begin
      j = p - 6;
      r = mk(OP_ARITH, cov_a(1, j), A_DT, cov_a(3, j), 1'b1, 1'b0, A_ZR, A_ZR,
             1'b0, 1'b0, A_A1 + addr_t'(j), 1'b1, 1'b0);
    end else if (p >= 10 && p <= 19) begin
      k = p - 10;
      i = TRI_ROW[k];
      j = TRI_COL[k];
      if (j == 0)
        r = mk(OP_ARITH, a_a(i, 0), A_DT, a_a(i, 2), 1'b1, 1'b0, A_ZR, A_ZR,
               1'b0, 1'b0, A_B0 + addr_t'(k), 1'b1, 1'b0);
      else if (j == 1)
        r = mk(OP_ARITH, a_a(i, 1), A_DT, a_a(i, 3), 1'b1, 1'b0, A_ZR, A_ZR,
               1'b0, 1'b0, A_B0 + addr_t'(k), 1'b1, 1'b0);
      else
        r = mk(OP_ARITH, a_a(i, j), A_ZR, A_ZR, 1'b0, 1'b0, A_ZR, A_ZR,
               1'b0, 1'b0, A_B0 + addr_t'(k), 1'b1, 1'b0);
    end else if (p >= 20 && p <= 23) begin
      k = DIAG_K[p - 20];
      r = mk(OP_ARITH, A_B0 + addr_t'(k), (k < 5) ? A_QP : A_QV, A_ZR, 1'b0, 1'b0,
             A_ZR, A_ZR, 1'b0, 1'b0, A_B0 + addr_t'(k), 1'b1, 1'b0);
    end else if (p == 24) begin
      r = mk(OP_ARITH, A_B0, A_RM, A_ZR, 1'b0, 1'b0, A_ZR, A_ZR, 1'b0, 1'b0,
             A_S00, 1'b1, 1'b0);
    end else if (p == 25) begin
      r = mk(OP_ARITH, b_a(1, 1), A_RM, A_ZR, 1'b0, 1'b0, A_ZR, A_ZR, 1'b0, 1'b0,
             A_S11, 1'b1, 1'b0);
    end else if (p == 26) begin
      r = mk(OP_ARITH, A_ZR, A_S00, A_S11, 1'b1, 1'b0, b_a(0, 1), b_a(0, 1),
             1'b1, 1'b1, A_DET, 1'b0, 1'b0);
    end else if (p >= 27 && p <= 42) begin
      t = p - 27;
      i = t >> 2;
      case (t & 3)
        0: r = mk(OP_ARITH, A_ZR, b_a(i, 0), A_S11, 1'b1, 1'b0, b_a(i, 1),
                  b_a(0, 1), 1'b1, 1'b1, A_N, 1'b1, 1'b0);
        1: r = mk(OP_DIV, A_N, A_DET, A_ZR, 1'b0, 1'b0, A_ZR, A_ZR, 1'b0, 1'b0,
                  k_a(i, 0), 1'b1, 1'b0);
        2: r = mk(OP_ARITH, A_ZR, b_a(i, 1), A_S00, 1'b1, 1'b0, b_a(i, 0),
                  b_a(0, 1), 1'b1, 1'b1, A_N, 1'b1, 1'b0);
        default: r = mk(OP_DIV, A_N, A_DET, A_ZR, 1'b0, 1'b0, A_ZR, A_ZR, 1'b0,
                        1'b0, k_a(i, 1), 1'b1, 1'b0);
      endcase
    end else if (p == 43) begin
      r = mk(OP_ARITH, A_MX, A_PX, A_ZR, 1'b0, 1'b1, A_ZR, A_ZR, 1'b0, 1'b0,
             A_EX, 1'b1, 1'b0);
    end else if (p == 44) begin
      r = mk(OP_ARITH, A_MY, A_PY, A_ZR, 1'b0, 1'b1, A_ZR, A_ZR, 1'b0, 1'b0,
             A_EY, 1'b1, 1'b0);
    end else if (p >= 45 && p <= 48) begin
      i = p - 45;
      pred = (i == 0) ? A_PX : (i == 1) ? A_PY : A_E0 + addr_t'(i);
      r = mk(OP_ARITH, pred, k_a(i, 0), A_EX, 1'b1, 1'b0, k_a(i, 1), A_EY,
             1'b1, 1'b0, A_E0 + addr_t'(i), 1'b1, 1'b0);
    end else if (p >= 49 && p <= 58) begin
      k = p - 49;
      i = TRI_ROW[k];
      j = TRI_COL[k];
      r = mk(OP_ARITH, b_a(i, j), k_a(i, 0), b_a(0, j), 1'b1, 1'b1, k_a(i, 1),
             b_a(1, j), 1'b1, 1'b1, A_C0 + addr_t'(k), 1'b1, p == 58);
    end else if (p >= 59 && p <= 62) begin
      i = p - 59;
      r = mk(OP_ARITH, (i == 0) ? A_MX : (i == 1) ? A_MY : A_ZR, A_ZR, A_ZR, 1'b0,
             1'b0, A_ZR, A_ZR, 1'b0, 1'b0, A_E0 + addr_t'(i), 1'b1, p == 62);
    end
    return r;
  endfunction

endpackage

### design/constant_velocity_kalman_tracker.sv
// ---------------------------------------------------------------------------
// Constant velocity Kalman tracker
// Four-state position/velocity tracker run by a microcoded sequencer around
// one shared multiplier, one accumulator and a radix-2 divider.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall) carry mode, dt_q16 and a measured position.
//   Each input beat yields exactly one output beat (out_valid/out_stall) with
//   the position and the tracking flag. Configuration writes (cfg_we,
//   cfg_index, cfg_data) set q_pos, q_vel and r_meas; the user must make
//   them only while the block is idle, as the block does not enforce it.
//   One item is worked on at a time; in_stall is high from acceptance until
//   the result has been handed to the output register.
//   Every arithmetic step reads its operands in turn on the single scratch
//   store read port; a gain step runs through the bit-serial divider.
//   After reset an initial pass loads estimate and covariance; no input
//   beat is accepted then. A stalled output beat holds; the block works the
//   next item up to its final write-back and then waits until the output
//   register is free.
// ---------------------------------------------------------------------------
`include "constant_velocity_kalman_tracker_macros.svh"

module constant_velocity_kalman_tracker
  import cvkt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [63:0] ONE_Q  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_Q = 64'd1 << (FRAC_BITS - 1);
  localparam logic [31:0] INIT_POS = 32'((ONE_Q + 64'd5) / 64'd10);
  localparam logic [31:0] INIT_VEL = 32'((ONE_Q + 64'd50) / 64'd100);
  localparam logic [31:0] INIT_R   = 32'(64'd5 * ONE_Q);
  localparam logic [31:0] NEG_ONE  = 32'(-ONE_Q);
  localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic [1:0] REG_Q_POS = 2'd0;
  localparam logic [1:0] REG_Q_VEL = 2'd1;
  localparam logic [1:0] REG_R     = 2'd2;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;

  localparam logic [3:0] PH_RC   = 4'd0;
  localparam logic [3:0] PH_RA0  = 4'd1;
  localparam logic [3:0] PH_RB0  = 4'd2;
  localparam logic [3:0] PH_RA1  = 4'd3;
  localparam logic [3:0] PH_RB1  = 4'd4;
  localparam logic [3:0] PH_CA1  = 4'd5;
  localparam logic [3:0] PH_CB1  = 4'd6;
  localparam logic [3:0] PH_MUL0 = 4'd7;
  localparam logic [3:0] PH_ACC0 = 4'd8;
  localparam logic [3:0] PH_ACC1 = 4'd9;
  localparam logic [3:0] PH_WB   = 4'd10;
  localparam logic [3:0] PH_DIV  = 4'd11;
  localparam logic [3:0] PH_DFIN = 4'd12;

  localparam logic [3:0] INIT_LAST = 4'd13;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  ph_r, ph_nxt;
  pc_t         pc_r, pc_nxt;
  logic [3:0]  init_cnt_r;
  logic        started_r;
  logic        mode_r;
  logic [31:0] dt_r;
  logic signed [31:0] mx_r, my_r;
  logic [31:0] qp_r, qv_r, rm_r;

  logic signed [63:0] mem [64];
  logic signed [63:0] rd_r, spec_r, opnd;
  logic        spec_sel_r;
  logic signed [63:0] oc_r, oa0_r, ob0_r, oa1_r, ob1_r;
  logic signed [63:0] prod_r, acc_r;
  logic [63:0] dvd_r, dsr_r, rem_r;
  logic        dneg_r, dzero_r;
  logic [6:0]  dcnt_r;
  logic signed [31:0] res_x_r, res_y_r;
  out_t        out_r;
  logic        out_valid_r;

  instr_t      ins;
  addr_t       raddr;
  logic signed [63:0] spec_val;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p, mq_p, t0, t1, wb_val;
  logic [63:0] rem_s, num_mag;
  logic        rem_ge;
  logic        out_free, in_acc, wb_fire;
  logic        mem_we;
  addr_t       mem_waddr;
  logic signed [63:0] mem_wdata;
  logic signed [31:0] fin_x, fin_y;

  assign ins      = prog(pc_r);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (ph_r)
      PH_RA0:  raddr = ins.a0;
      PH_RB0:  raddr = ins.b0;
      PH_RA1:  raddr = ins.a1;
      PH_RB1:  raddr = ins.b1;
      default: raddr = ins.c;
    endcase
  end

  always_comb begin
    case (raddr)
      A_DT:    spec_val = {32'd0, dt_r};
      A_QP:    spec_val = {32'd0, qp_r};
      A_QV:    spec_val = {32'd0, qv_r};
      A_RM:    spec_val = {32'd0, rm_r};
      A_MX:    spec_val = 64'(mx_r);
      A_MY:    spec_val = 64'(my_r);
      default: spec_val = '0;
    endcase
  end

  assign opnd  = spec_sel_r ? spec_r : rd_r;
  assign mul_a = (ph_r == PH_ACC0) ? oa1_r[31:0] : oa0_r[31:0];
  assign mul_b = (ph_r == PH_ACC0) ? ob1_r[31:0] : ob0_r[31:0];
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign mq_p  = (prod_r + signed'(HALF_Q)) >>> FRAC_BITS;
  assign t0    = ins.m0 ? mq_p : oa0_r;
  assign t1    = ins.m1 ? mq_p : oa1_r;
  assign wb_val = ins.sat ? sat32(acc_r) : acc_r;
  assign wb_fire = (state_r == ST_RUN) && (ph_r == PH_WB) && (!ins.last || out_free);
  assign fin_x = (ins.dst == A_PX || ins.dst == A_E0) ? wb_val[31:0] : res_x_r;
  assign fin_y = (ins.dst == A_PY || ins.dst == A_E0 + 6'd1) ? wb_val[31:0] : res_y_r;

  assign rem_s   = {rem_r[62:0], dvd_r[63]};
  assign rem_ge  = (rem_s >= dsr_r);
  assign num_mag = oc_r[63] ? 64'(-oc_r) : 64'(oc_r);

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    pc_nxt    = pc_r;
    case (state_r)
      ST_INIT: begin
        if (init_cnt_r == INIT_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          ph_nxt = PH_RC;
          if (in_data.mode) begin
            state_nxt = started_r ? ST_RUN : ST_FIX;
            pc_nxt    = PC_PRED;
          end else begin
            state_nxt = ST_RUN;
            pc_nxt    = started_r ? PC_UPD : PC_INIT;
          end
        end
      end
      ST_RUN: begin
        case (ph_r)
          PH_MUL0: ph_nxt = (ins.op == OP_DIV) ? PH_DIV : PH_ACC0;
          PH_DIV:  ph_nxt = (dcnt_r == 7'd1) ? PH_DFIN : PH_DIV;
          PH_DFIN: ph_nxt = PH_WB;
          PH_WB: begin
            if (wb_fire) begin
              ph_nxt = PH_RC;
              if (ins.last) state_nxt = ST_IDLE;
              else pc_nxt = pc_r + 7'd1;
            end
          end
          default: ph_nxt = ph_r + 4'd1;
        endcase
      end
      ST_FIX: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = A_ZR;
    mem_wdata = '0;
    if (state_r == ST_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = addr_t'(init_cnt_r);
      case (addr_t'(init_cnt_r))
        A_C0, A_C0 + 6'd4:        mem_wdata = {32'd0, INIT_POS};
        A_C0 + 6'd7, A_C0 + 6'd9: mem_wdata = {32'd0, INIT_VEL};
        default:                  mem_wdata = '0;
      endcase
    end else if (wb_fire) begin
      mem_we    = 1'b1;
      mem_waddr = ins.dst;
      mem_wdata = wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r       <= mem[raddr];
    spec_r     <= spec_val;
    spec_sel_r <= (raddr >= A_SPECIAL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ph_r        <= PH_RC;
      pc_r        <= PC_UPD;
      init_cnt_r  <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      qp_r        <= INIT_POS;
      qv_r        <= INIT_VEL;
      rm_r        <= INIT_R;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      pc_r    <= pc_nxt;
      if (state_r == ST_INIT) init_cnt_r <= init_cnt_r + 4'd1;
      if (cfg_we) begin
        case (cfg_index)
          REG_Q_POS: qp_r <= cfg_data;
          REG_Q_VEL: qv_r <= cfg_data;
          REG_R:     rm_r <= cfg_data;
          default:   ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (wb_fire && ins.last) begin
        out_valid_r <= 1'b1;
        if (!mode_r) started_r <= 1'b1;
      end
      if (state_r == ST_FIX && out_free) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_data.mode;
      dt_r   <= ({12'd0, in_data.dt_q16} << SH_L) >> SH_R;
      mx_r   <= in_data.meas_x;
      my_r   <= in_data.meas_y;
    end
    if (state_r == ST_RUN) begin
      case (ph_r)
        PH_RA0:  oc_r  <= opnd;
        PH_RB0:  oa0_r <= opnd;
        PH_RA1:  ob0_r <= opnd;
        PH_RB1:  oa1_r <= opnd;
        PH_CA1:  ob1_r <= opnd;
        PH_MUL0: begin
          prod_r  <= mul_p;
          dvd_r   <= num_mag << FRAC_BITS;
          dsr_r   <= oa0_r[63] ? 64'(-oa0_r) : 64'(oa0_r);
          rem_r   <= '0;
          dneg_r  <= oc_r[63] ^ oa0_r[63];
          dzero_r <= (oa0_r == 64'sd0);
          dcnt_r  <= 7'd64;
        end
        PH_ACC0: begin
          acc_r  <= ins.n0 ? oc_r - t0 : oc_r + t0;
          prod_r <= mul_p;
        end
        PH_ACC1: acc_r <= ins.n1 ? acc_r - t1 : acc_r + t1;
        PH_DIV: begin
          rem_r  <= rem_ge ? rem_s - dsr_r : rem_s;
          dvd_r  <= {dvd_r[62:0], rem_ge};
          dcnt_r <= dcnt_r - 7'd1;
        end
        PH_DFIN: acc_r <= dzero_r ? 64'sd0 : (dneg_r ? -signed'(dvd_r) : signed'(dvd_r));
        default: ;
      endcase
    end
    if (wb_fire) begin
      res_x_r <= fin_x;
      res_y_r <= fin_y;
      if (ins.last) begin
        out_r.pos_x    <= fin_x;
        out_r.pos_y    <= fin_y;
        out_r.tracking <= 1'b1;
      end
    end
    if (state_r == ST_FIX && out_free) begin
      out_r.pos_x    <= NEG_ONE;
      out_r.pos_y    <= NEG_ONE;
      out_r.tracking <= 1'b0;
    end
  end

  `CVKT_ASSERT_IMP(a_pc_range, state_r == ST_RUN, pc_r <= PC_MAX)
  `CVKT_ASSERT_IMP(a_wb_dst, wb_fire, ins.dst < A_SPECIAL)
  `CVKT_ASSERT_IMP(a_untracked_flag, out_valid_r && !started_r, !out_r.tracking)
  `CVKT_ASSERT_NXT(a_div_count, state_r == ST_RUN && ph_r == PH_MUL0 && ins.op == OP_DIV,
                   ph_r == PH_DIV && dcnt_r == 7'd64)

endmodule

### dv/cvkt_test_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tracker test codes
// Register indexes and item modes shared by the stimulus and the checker.
// ---------------------------------------------------------------------------
package cvkt_test_pkg;

  localparam logic [1:0] REG_Q_POS  = 2'd0;
  localparam logic [1:0] REG_Q_VEL  = 2'd1;
  localparam logic [1:0] REG_R_MEAS = 2'd2;

  localparam logic MODE_UPDATE  = 1'b0;
  localparam logic MODE_PREDICT = 1'b1;

endpackage

### dv/constant_velocity_kalman_tracker_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tracker checker
// Watches the input, output and register ports, runs a fixed-point tracker
// of its own on every accepted input beat and compares each output beat
// with the oldest expected position and tracking flag.
// ---------------------------------------------------------------------------
module constant_velocity_kalman_tracker_checker
  import cvkt_pkg::*;
  import cvkt_test_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          open_count
);

  localparam int FB = 16;
  localparam longint ONE_FX = longint'(1) << FB;
  localparam longint HALF_FX = longint'(1) << (FB - 1);

  longint noise_pos, noise_vel, noise_meas;
  bit     locked;
  longint track[4];
  longint spread[10];
  out_t   expected_pos[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + HALF_FX) >>> FB;
  endfunction

  task automatic restart_track();
    noise_pos = (ONE_FX + 5) / 10;
    noise_vel = (ONE_FX + 50) / 100;
    noise_meas = 5 * ONE_FX;
    locked = 0;
    for (int k = 0; k < 4; k++) track[k] = 0;
    for (int k = 0; k < 10; k++) spread[k] = 0;
    spread[0] = (ONE_FX + 5) / 10;
    spread[4] = (ONE_FX + 5) / 10;
    spread[7] = (ONE_FX + 50) / 100;
    spread[9] = (ONE_FX + 50) / 100;
  endtask

  function automatic out_t track_step(in_t it);
    out_t   r;
    longint dt, mx, my, px, py, s00, s01, s11, det, ex, ey, v, n0, n1;
    longint P[4][4], A[4][4], B[4][4], K[4][2], pred[4];
    int     i, j;
    dt = longint'(it.dt_q16);
    mx = longint'(it.meas_x);
    my = longint'(it.meas_y);
    px = clamp32(track[0] + fx_mul(dt, track[2]));
    py = clamp32(track[1] + fx_mul(dt, track[3]));
    if (it.mode == MODE_PREDICT) begin
      if (!locked) begin
        r.pos_x = -32'sd65536;
        r.pos_y = -32'sd65536;
        r.tracking = 1'b0;
      end else begin
        r.pos_x = px[31:0];
        r.pos_y = py[31:0];
        r.tracking = 1'b1;
      end
      return r;
    end
    if (!locked) begin
      locked = 1;
      track[0] = mx;
      track[1] = my;
      track[2] = 0;
      track[3] = 0;
    end else begin
      pred[0] = px; pred[1] = py; pred[2] = track[2]; pred[3] = track[3];
      for (int k = 0; k < 10; k++) begin
        P[TRI_ROW[k]][TRI_COL[k]] = spread[k];
        P[TRI_COL[k]][TRI_ROW[k]] = spread[k];
      end
      for (int c = 0; c < 4; c++) begin
        A[0][c] = clamp32(P[0][c] + fx_mul(dt, P[2][c]));
        A[1][c] = clamp32(P[1][c] + fx_mul(dt, P[3][c]));
        A[2][c] = P[2][c];
        A[3][c] = P[3][c];
      end
      for (int k = 0; k < 10; k++) begin
        i = TRI_ROW[k];
        j = TRI_COL[k];
        if (j == 0) v = clamp32(A[i][0] + fx_mul(dt, A[i][2]));
        else if (j == 1) v = clamp32(A[i][1] + fx_mul(dt, A[i][3]));
        else v = A[i][j];
        if (i == j) v = clamp32(v + ((i < 2) ? noise_pos : noise_vel));
        B[i][j] = v;
        B[j][i] = v;
      end
      s00 = clamp32(B[0][0] + noise_meas);
      s01 = B[0][1];
      s11 = clamp32(B[1][1] + noise_meas);
      det = fx_mul(s00, s11) - fx_mul(s01, s01);
      for (int m = 0; m < 4; m++) begin
        n0 = clamp32(fx_mul(B[m][0], s11) - fx_mul(B[m][1], s01));
        n1 = clamp32(fx_mul(B[m][1], s00) - fx_mul(B[m][0], s01));
        K[m][0] = (det != 0) ? clamp32((n0 * ONE_FX) / det) : 0;
        K[m][1] = (det != 0) ? clamp32((n1 * ONE_FX) / det) : 0;
      end
      ex = clamp32(mx - px);
      ey = clamp32(my - py);
      for (int m = 0; m < 4; m++)
        track[m] = clamp32(pred[m] + fx_mul(K[m][0], ex) + fx_mul(K[m][1], ey));
      for (int k = 0; k < 10; k++) begin
        i = TRI_ROW[k];
        j = TRI_COL[k];
        spread[k] = clamp32(B[i][j] - fx_mul(K[i][0], B[0][j])
                            - fx_mul(K[i][1], B[1][j]));
      end
    end
    r.pos_x = track[0][31:0];
    r.pos_y = track[1][31:0];
    r.tracking = 1'b1;
    return r;
  endfunction

  assign open_count = expected_pos.size();

  initial begin
    fail_count = 0;
    restart_track();
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      restart_track();
      expected_pos.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_Q_POS:  noise_pos = longint'(cfg_data);
          REG_Q_VEL:  noise_vel = longint'(cfg_data);
          REG_R_MEAS: noise_meas = longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_pos.push_back(track_step(in_data));
      if (out_valid && !out_stall) begin
        if (expected_pos.size() == 0) begin
          $error("unexpected output beat pos_x %0d pos_y %0d",
                 out_data.pos_x, out_data.pos_y);
          fail_count++;
        end else begin
          want = expected_pos.pop_front();
          if (out_data.pos_x !== want.pos_x) begin
            $error("pos_x expected %0d got %0d", want.pos_x, out_data.pos_x);
            fail_count++;
          end
          if (out_data.pos_y !== want.pos_y) begin
            $error("pos_y expected %0d got %0d", want.pos_y, out_data.pos_y);
            fail_count++;
          end
          if (out_data.tracking !== want.tracking) begin
            $error("tracking expected %0d got %0d", want.tracking, out_data.tracking);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### dv/constant_velocity_kalman_tracker_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tracker testbench
// Resets the tracker, runs directed edge items, then six phases of random
// target trajectories and noise under several noise settings and idle mixes.
// The checker beside the block predicts and compares every output beat.
// ---------------------------------------------------------------------------
module constant_velocity_kalman_tracker_test;
  import cvkt_pkg::*;
  import cvkt_test_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_Q_POS;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          open_count;

  int send_idle = 0;
  int recv_idle = 0;
  int n_update = 0;
  int n_predict = 0;
  int tx, ty, tvx, tvy;

  always #5 clk = ~clk;

  constant_velocity_kalman_tracker u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  constant_velocity_kalman_tracker_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .open_count(open_count)
  );

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle);

  initial begin
    #200_000_000;
    $display("constant_velocity_kalman_tracker_test: errors");
    $finish;
  end

  task automatic send(logic mode, logic [19:0] dt, logic [31:0] mx, logic [31:0] my);
    in_t b;
    b.mode = mode;
    b.dt_q16 = dt;
    b.meas_x = mx;
    b.meas_y = my;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mode == MODE_UPDATE) n_update++;
    else n_predict++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int kind;
    logic [19:0] dt;
    kind = $urandom_range(0, 99);
    dt = 20'($urandom_range(0, 13107));
    if (kind < 5) begin
      tx = $urandom_range(0, 32'h00ffffff) - 32'h00800000;
      ty = $urandom_range(0, 32'h00ffffff) - 32'h00800000;
      tvx = $urandom_range(0, 32'h7fff) - 32'h4000;
      tvy = $urandom_range(0, 32'h7fff) - 32'h4000;
    end
    if (kind < 60) begin
      tx += tvx;
      ty += tvy;
      send(MODE_UPDATE, dt, tx + $urandom_range(0, 131072) - 65536,
           ty + $urandom_range(0, 131072) - 65536);
    end else if (kind < 85) begin
      send(MODE_PREDICT, dt, $urandom, $urandom);
    end else begin
      send(logic'($urandom_range(0, 1)), 20'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    logic [31:0] qp, qv, rm;
    tx = 0; ty = 0; tvx = 1000; tvy = -700;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(MODE_PREDICT, 20'hfffff, 32'h7fffffff, 32'h80000000);
    send(MODE_PREDICT, 20'h0, 32'h0, 32'h0);
    send(MODE_UPDATE, 20'h0, 32'h80000000, 32'h7fffffff);
    send(MODE_PREDICT, 20'h0, 32'h0, 32'h0);
    send(MODE_PREDICT, 20'hfffff, 32'hffffffff, 32'hffffffff);
    send(MODE_UPDATE, 20'hfffff, 32'h7fffffff, 32'h80000000);
    send(MODE_PREDICT, 20'hfffff, 32'h0, 32'h0);
    send(MODE_UPDATE, 20'h0, 32'h0, 32'h0);
    send(MODE_UPDATE, 20'hfffff, 32'hffffffff, 32'h00000001);
    send(MODE_UPDATE, 20'h10000, 32'h00010000, 32'hffff0000);
    for (int k = 0; k < 8; k++) send(MODE_UPDATE, 20'h03333, 32'(k * 65536), 32'h0);
    send(MODE_PREDICT, 20'h10000, 32'h0, 32'h0);
    send(MODE_PREDICT, 20'hfffff, 32'h0, 32'h0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle = 12; recv_idle = 47; end
        1: begin send_idle = 47; recv_idle = 12; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (ph)
        0: begin qp = 32'h0; qv = 32'h0; rm = 32'h0; end
        1: begin qp = 32'hffffffff; qv = 32'hffffffff; rm = 32'hffffffff; end
        4: begin qp = 32'd6554; qv = 32'd655; rm = 32'd327680; end
        5: begin qp = $urandom; qv = $urandom; rm = $urandom; end
        default: begin
          qp = $urandom_range(0, 65536);
          qv = $urandom_range(0, 6554);
          rm = $urandom_range(0, 1310720);
        end
      endcase
      write_reg(REG_Q_POS, qp);
      write_reg(REG_Q_VEL, qv);
      write_reg(REG_R_MEAS, rm);
      if (ph == 0)
        for (int k = 0; k < 10; k++) send(MODE_UPDATE, 20'h0, 32'h00050000, 32'h00030000);
      for (int k = 0; k < 290; k++) random_item();
      drain();
    end

    $display("covered %0d update and %0d predict beats over six noise settings",
             n_update, n_predict);
    $display("with sender and receiver idling in both mixes and back-to-back");
    if (fail_count == 0)
      $display("constant_velocity_kalman_tracker_test: clean");
    else
      $display("constant_velocity_kalman_tracker_test: errors");
    $finish;
  end

endmodule

### constant_velocity_kalman_tracker.f
+incdir+design
design/cvkt_pkg.sv
design/constant_velocity_kalman_tracker.sv
dv/cvkt_test_pkg.sv
dv/constant_velocity_kalman_tracker_checker.sv
dv/constant_velocity_kalman_tracker_test.sv
